>>> sv/xtea_pkg.sv
// shared types, constants and register indexes for the xtea block cipher
// no dependencies; imported by xtea_half_cell and xtea_block_cipher
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

   localparam int WORD_W      = 32;
   localparam int KEY_WORDS   = 4;
   localparam int KEY_SEL_W   = 2;
   localparam int CSR_INDEX_W = 3;

   // round count default, a top level parameter
   localparam int ROUNDS_DEFAULT = 32;

   // round function shifts and key select position in the sum
   localparam int MIX_SHIFT_LEFT  = 4;
   localparam int MIX_SHIFT_RIGHT = 5;
   localparam int KEY_SEL_LO      = 0;
   localparam int KEY_SEL_HI      = 11;

   localparam logic [WORD_W-1:0] DELTA_RESET = 32'h9E37_79B9;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELTA = 3'd4;

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [KEY_WORDS-1:0] key_type;

   typedef enum logic {
      CMD_ENCRYPT = 1'b0,
      CMD_DECRYPT = 1'b1
   } command_type;

   // one block in flight between two cells
   typedef struct packed {
      logic        valid;
      command_type command;
      word_type    left;
      word_type    right;
      word_type    sum;
   } stage_type;

endpackage

`default_nettype wire

>>> sv/xtea_half_cell.sv
// one feistel half-round of xtea with its stage register
// depends on xtea_pkg
`timescale 1ns / 1ps
`default_nettype none

module xtea_half_cell #(
   parameter bit SECOND_HALF = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  xtea_pkg::key_type   key,
   input  xtea_pkg::word_type  delta,
   input  xtea_pkg::stage_type stage_i,
   output xtea_pkg::stage_type stage_o
);
   import xtea_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   stage_type            data_ff;
   stage_type            data_in;
   logic                 is_decrypt;
   logic                 update_left;
   word_type             source;
   word_type             mixed;
   word_type             tweak;
   logic [KEY_SEL_W-1:0] key_sel;

   always_comb begin
      is_decrypt  = (stage_i.command == CMD_DECRYPT);
      // encrypt: first half updates left; decrypt runs the halves mirrored
      update_left = is_decrypt ^ !SECOND_HALF;
      source      = update_left ? stage_i.right : stage_i.left;
      mixed       = ((source << MIX_SHIFT_LEFT) ^ (source >> MIX_SHIFT_RIGHT)) + source;
      key_sel     = update_left ? stage_i.sum[KEY_SEL_LO +: KEY_SEL_W]
                                : stage_i.sum[KEY_SEL_HI +: KEY_SEL_W];
      tweak       = mixed ^ (stage_i.sum + key[key_sel]);

      data_in = stage_i;
      if (update_left) begin
         data_in.left = is_decrypt ? stage_i.left - tweak : stage_i.left + tweak;
      end else begin
         data_in.right = is_decrypt ? stage_i.right - tweak : stage_i.right + tweak;
      end
      // the sum steps between the two halves of a round
      if (!SECOND_HALF) begin
         data_in.sum = is_decrypt ? stage_i.sum - delta : stage_i.sum + delta;
      end

      valid_in = advance ? stage_i.valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      stage_o       = data_ff;
      stage_o.valid = valid_ff;
   end

endmodule

`default_nettype wire

>>> sv/xtea_block_cipher.sv
// xtea block cipher top level: csr registers and a chain of 2*ROUNDS half-round cells
// a request is registered into the first cell when accepted and moves down the chain on each
// advance; the last cell drives the response, which waits there while rsp_ready is low
// throughput: one request per cycle; the whole chain shifts on one advance enable,
// held only while the last cell holds a result that rsp_ready does not take
// reset: chain empty, key words 0, round_delta 0x9E3779B9; depends on xtea_pkg, xtea_half_cell
`timescale 1ns / 1ps
`default_nettype none

module xtea_block_cipher #(
   parameter int ROUNDS = xtea_pkg::ROUNDS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 csr_write_en,
   input  logic [xtea_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  xtea_pkg::word_type                   csr_wdata,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  xtea_pkg::command_type                req_command,
   input  xtea_pkg::word_type                   req_block_left,
   input  xtea_pkg::word_type                   req_block_right,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output xtea_pkg::word_type                   rsp_result_left,
   output xtea_pkg::word_type                   rsp_result_right
);
   import xtea_pkg::*;

   localparam int HALF_STEPS = 2 * ROUNDS;
   localparam int ROUNDS_W   = $clog2(ROUNDS + 1);
   localparam int PROD_W     = WORD_W + ROUNDS_W;
   // decrypt starting sum for the reset delta, wrapped to a word
   localparam logic [63:0] DEC_SUM_RESET_WIDE = 64'(DELTA_RESET) * 64'(ROUNDS);
   localparam word_type    DEC_SUM_RESET      = DEC_SUM_RESET_WIDE[WORD_W-1:0];

   // configuration registers
   key_type             key_ff;
   key_type             key_in;
   word_type            delta_ff;
   word_type            delta_in;
   // decrypt start sum kept alongside delta so no multiply sits in the datapath
   word_type            dec_sum_ff;
   word_type            dec_sum_in;
   logic [PROD_W-1:0]   dec_sum_prod;

   logic                advance;
   stage_type           stage [0:HALF_STEPS];

   // csr write decode; writes past the delta index are dropped
   always_comb begin
      key_in       = key_ff;
      delta_in     = delta_ff;
      dec_sum_in   = dec_sum_ff;
      dec_sum_prod = {{ROUNDS_W{1'b0}}, csr_wdata} * PROD_W'(ROUNDS);
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_KEY_0: key_in[0] = csr_wdata;
            CSR_KEY_1: key_in[1] = csr_wdata;
            CSR_KEY_2: key_in[2] = csr_wdata;
            CSR_KEY_3: key_in[3] = csr_wdata;
            CSR_DELTA: begin
               delta_in   = csr_wdata;
               dec_sum_in = dec_sum_prod[WORD_W-1:0];
            end
            default: begin
               key_in = key_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff     <= '0;
         delta_ff   <= DELTA_RESET;
         dec_sum_ff <= DEC_SUM_RESET;
      end else begin
         key_ff     <= key_in;
         delta_ff   <= delta_in;
         dec_sum_ff <= dec_sum_in;
      end
   end

   // chain moves unless the finished result at the end is stalled
   assign advance   = !stage[HALF_STEPS].valid || rsp_ready;
   assign req_ready = advance;

   // head of the chain: request enters with its starting sum
   always_comb begin
      stage[0].valid   = req_valid;
      stage[0].command = req_command;
      stage[0].left    = req_block_left;
      stage[0].right   = req_block_right;
      stage[0].sum     = (req_command == CMD_DECRYPT) ? dec_sum_ff : '0;
   end

   // even cells are the first half of a round, odd cells the second
   for (genvar i = 0; i < HALF_STEPS; i++) begin : g_cell
      xtea_half_cell #(
         .SECOND_HALF (1'(i % 2))
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .key     (key_ff),
         .delta   (delta_ff),
         .stage_i (stage[i]),
         .stage_o (stage[i+1])
      );
   end

   // last cell register doubles as the output register
   assign rsp_valid        = stage[HALF_STEPS].valid;
   assign rsp_result_left  = stage[HALF_STEPS].left;
   assign rsp_result_right = stage[HALF_STEPS].right;

`ifndef NO_ASSERTIONS
   a_dec_sum_tracks_delta: assert property (@(posedge clock) disable iff (reset)
      dec_sum_ff == word_type'({{ROUNDS_W{1'b0}}, delta_ff} * PROD_W'(ROUNDS)))
      else $error("decrypt start sum out of step with round delta");

   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> stage[1].valid)
      else $error("accepted request missing from first cell");

   a_stall_holds_chain: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(stage[1]))
      else $error("first cell changed while the chain was stalled");

   a_result_leaves_on_ready: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> $past(rsp_ready))
      else $error("result dropped without rsp_ready");
`endif

endmodule

`default_nettype wire
